/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the validator modules.
// Every macro samples on the rising edge of clk_i and is quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define POV_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When ante holds, cons must hold in the same cycle.
`define POV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define POV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pov_pkg.sv */
// ----------------------------------------------------------------------------
// Peer offer validator package
// Types, register map and constants shared by the validator modules.
// ----------------------------------------------------------------------------
package pov_pkg;

  localparam int OctetW     = 8;
  localparam int LenW       = 16;
  localparam int ErrW       = 5;
  localparam int CfgDataW   = 32;
  localparam int CfgNumRegs = 6;
  localparam int CfgIdxW    = 3;
  localparam int CfgAddrW   = CfgIdxW + 2;

  // Depth of the queue between the classifier and the TLV walker.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = 2;
  localparam int QueueCntW  = 3;

  localparam logic [OctetW-1:0] ShortTlvLen  = 8'd2;
  localparam logic [OctetW-1:0] V4TlvLen     = 8'd6;
  localparam logic [OctetW-1:0] V6TlvLen     = 8'd18;
  localparam logic [OctetW-1:0] V4FullPrefix = 8'd32;
  localparam logic [OctetW-1:0] V6FullPrefix = 8'd128;
  localparam logic [OctetW-1:0] AddFlag      = 8'd1;
  localparam logic [LenW-1:0]   MinPacket    = 16'd3;

  typedef enum logic [CfgIdxW-1:0] {
    RegOffer = 3'd0,
    RegPort  = 3'd1,
    RegHb    = 3'd2,
    RegV4    = 3'd3,
    RegV6    = 3'd4,
    RegPeer  = 3'd5
  } cfg_reg_e;

  typedef enum logic [ErrW-1:0] {
    ErrNone       = 5'd0,
    ErrShort      = 5'd1,
    ErrType       = 5'd2,
    ErrLength     = 5'd3,
    ErrDupPort    = 5'd4,
    ErrPortLen    = 5'd5,
    ErrDupHb      = 5'd6,
    ErrHbLen      = 5'd7,
    ErrAddrLen    = 5'd8,
    ErrAddFlag    = 5'd9,
    ErrPrefix     = 5'd10,
    ErrDupPeer    = 5'd11,
    ErrPeerNul    = 5'd12,
    ErrUnknownTlv = 5'd13,
    ErrNoAddr     = 5'd14,
    ErrNoPort     = 5'd15,
    ErrNoHb       = 5'd16,
    ErrOverrun    = 5'd17
  } err_e;

  typedef struct packed {
    logic [OctetW-1:0] octet;
    logic              final_octet;
  } in_beat_t;

  typedef struct packed {
    logic            accepted;
    logic [ErrW-1:0] error_code;
  } result_t;

  typedef struct packed {
    logic [OctetW-1:0] offer_code;
    logic [OctetW-1:0] port_code;
    logic [OctetW-1:0] hb_code;
    logic [OctetW-1:0] v4_code;
    logic [OctetW-1:0] v6_code;
    logic [OctetW-1:0] peer_code;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    offer_code: 8'd0,
    port_code:  8'd1,
    hb_code:    8'd2,
    v4_code:    8'd3,
    v6_code:    8'd4,
    peer_code:  8'd5
  };

  // A byte together with every comparison the walker may need for it.
  typedef struct packed {
    logic [OctetW-1:0] octet;
    logic              final_octet;
    logic              is_offer;
    logic              m_port;
    logic              m_hb;
    logic              m_v4;
    logic              m_v6;
    logic              m_peer;
    logic              is_zero;
    logic              is_add;
    logic              is_short_len;
    logic              is_v4_len;
    logic              is_v6_len;
    logic              is_v4_full;
    logic              is_v6_full;
  } cls_beat_t;

endpackage

/* hw/rtl/peer_offer_tlv_validator.sv */
// ----------------------------------------------------------------------------
// Peer offer TLV validator
// Streams a peer offer signal byte by byte and reports accept or first error.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload                Direction
//   --------  ---------------------  ---------------------  ---------
//   bytes     push / full            in_beat_i (in_beat_t)  in
//   verdicts  empty / pop            result_o (result_t)    out
//   config    psel/penable/pready    paddr, pwdata, prdata  in/out
//
// One byte beat is taken every clock cycle while full is low; the TLV
// walker consumes one beat per cycle from a four-entry queue while a
// verdict buffer entry is free; each verdict is registered for result_o.
// The two-entry verdict buffer stalls the walker only when both entries wait.
// Reset clears the queues and the walker and loads the default type codes.
//
// The front end compares each incoming byte against the configured type
// codes and the fixed length and prefix values, so the walker in the back
// end sees single-bit flags. The walker tracks the header (message
// type, big-endian length), the TLV phase and which mandatory TLVs were
// seen, keeps the first fault, and on the last byte ranks the faults into
// one error code and queues it. Configuration must be written only while
// no packet is in flight; the user must ensure this, the block does not.

module peer_offer_tlv_validator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Byte input queue interface.
  input  logic                          push,
  output logic                          full,
  input  pov_pkg::in_beat_t             in_beat_i,
  // Verdict output queue interface.
  output logic                          empty,
  input  logic                          pop,
  output pov_pkg::result_t              result_o,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pov_pkg::CfgAddrW-1:0]  paddr,
  input  logic [pov_pkg::CfgDataW-1:0]  pwdata,
  output logic [pov_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  pov_pkg::cfg_t      cfg;
  pov_pkg::cls_beat_t wr_beat;
  pov_pkg::cls_beat_t rd_beat;
  logic               q_wr;
  logic               q_rd;
  logic               q_full;
  logic               q_empty;

  pov_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pov_front u_front (
    .push      (push),
    .full      (full),
    .in_beat_i (in_beat_i),
    .cfg_i     (cfg),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_beat_o  (wr_beat)
  );

  pov_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_beat_i (wr_beat),
    .rd_i      (q_rd),
    .rd_beat_o (rd_beat),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  pov_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_beat_i  (rd_beat),
    .q_rd_o    (q_rd),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule

/* hw/rtl/pov_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Peer offer validator configuration registers
// APB-style register file holding the message and TLV type codes.
// ----------------------------------------------------------------------------
module pov_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pov_pkg::CfgAddrW-1:0]    paddr,
  input  logic [pov_pkg::CfgDataW-1:0]    pwdata,
  output logic [pov_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready,
  output pov_pkg::cfg_t                   cfg_o
);

  pov_pkg::cfg_t    cfg_q, cfg_d;
  pov_pkg::cfg_reg_e reg_sel;
  logic             wr_en;
  logic [pov_pkg::OctetW-1:0] rd_byte;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = pov_pkg::cfg_reg_e'(paddr[pov_pkg::CfgAddrW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        pov_pkg::RegOffer: cfg_d.offer_code = pwdata[pov_pkg::OctetW-1:0];
        pov_pkg::RegPort:  cfg_d.port_code  = pwdata[pov_pkg::OctetW-1:0];
        pov_pkg::RegHb:    cfg_d.hb_code    = pwdata[pov_pkg::OctetW-1:0];
        pov_pkg::RegV4:    cfg_d.v4_code    = pwdata[pov_pkg::OctetW-1:0];
        pov_pkg::RegV6:    cfg_d.v6_code    = pwdata[pov_pkg::OctetW-1:0];
        pov_pkg::RegPeer:  cfg_d.peer_code  = pwdata[pov_pkg::OctetW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      pov_pkg::RegOffer: rd_byte = cfg_q.offer_code;
      pov_pkg::RegPort:  rd_byte = cfg_q.port_code;
      pov_pkg::RegHb:    rd_byte = cfg_q.hb_code;
      pov_pkg::RegV4:    rd_byte = cfg_q.v4_code;
      pov_pkg::RegV6:    rd_byte = cfg_q.v6_code;
      pov_pkg::RegPeer:  rd_byte = cfg_q.peer_code;
      default:           rd_byte = '0;
    endcase
  end

  assign prdata = {{(pov_pkg::CfgDataW - pov_pkg::OctetW){1'b0}}, rd_byte};
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pov_pkg::CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hw/rtl/pov_front.sv */
// ----------------------------------------------------------------------------
// Peer offer validator front end
// Accepts input beats and tags each byte with its code and value comparisons.
// ----------------------------------------------------------------------------
module pov_front (
  input  logic                  push,
  output logic                  full,
  input  pov_pkg::in_beat_t     in_beat_i,
  input  pov_pkg::cfg_t         cfg_i,
  input  logic                  q_full_i,
  output logic                  q_wr_o,
  output pov_pkg::cls_beat_t    q_beat_o
);

  logic [pov_pkg::OctetW-1:0] b;

  assign b      = in_beat_i.octet;
  assign full   = q_full_i;
  assign q_wr_o = push && !q_full_i;

  // Compares against codes and constants happen here, so the walker sees single flags.
  always_comb begin
    q_beat_o.octet        = b;
    q_beat_o.final_octet  = in_beat_i.final_octet;
    q_beat_o.is_offer     = (b == cfg_i.offer_code);
    q_beat_o.m_port       = (b == cfg_i.port_code);
    q_beat_o.m_hb         = (b == cfg_i.hb_code);
    q_beat_o.m_v4         = (b == cfg_i.v4_code);
    q_beat_o.m_v6         = (b == cfg_i.v6_code);
    q_beat_o.m_peer       = (b == cfg_i.peer_code);
    q_beat_o.is_zero      = (b == '0);
    q_beat_o.is_add       = (b == pov_pkg::AddFlag);
    q_beat_o.is_short_len = (b == pov_pkg::ShortTlvLen);
    q_beat_o.is_v4_len    = (b == pov_pkg::V4TlvLen);
    q_beat_o.is_v6_len    = (b == pov_pkg::V6TlvLen);
    q_beat_o.is_v4_full   = (b == pov_pkg::V4FullPrefix);
    q_beat_o.is_v6_full   = (b == pov_pkg::V6FullPrefix);
  end

endmodule

/* hw/rtl/pov_queue.sv */
// ----------------------------------------------------------------------------
// Peer offer validator beat queue
// Short queue of classified beats between the front end and the TLV walker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pov_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  pov_pkg::cls_beat_t   wr_beat_i,
  input  logic                 rd_i,
  output pov_pkg::cls_beat_t   rd_beat_o,
  output logic                 full_o,
  output logic                 empty_o
);

  pov_pkg::cls_beat_t                mem_q [pov_pkg::QueueDepth];
  logic [pov_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [pov_pkg::QueueCntW-1:0]     cnt_q;
  logic                              wr_en, rd_en;

  assign full_o    = (cnt_q == pov_pkg::QueueCntW'(pov_pkg::QueueDepth));
  assign empty_o   = (cnt_q == '0);
  assign wr_en     = wr_i && !full_o;
  assign rd_en     = rd_i && !empty_o;
  assign rd_beat_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Fill level and pointers must stay in step.
  `POV_ASSERT_NEXT(a_q_fill, wr_en && !rd_en, cnt_q == $past(cnt_q) + 1'b1, "queue fill lost a write")
  `POV_ASSERT_IMPL(a_q_ptrs, !full_o && !empty_o, (wr_ptr_q - rd_ptr_q) == cnt_q[pov_pkg::QueuePtrW-1:0], "queue pointers disagree with fill level")

endmodule

/* hw/rtl/pov_back.sv */
// ----------------------------------------------------------------------------
// Peer offer validator back end
// Walks the header and TLVs byte by byte and queues one verdict per packet.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pov_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  pov_pkg::cls_beat_t   q_beat_i,
  output logic                 q_rd_o,
  output logic                 empty,
  input  logic                 pop,
  output pov_pkg::result_t     result_o
);

  typedef enum logic [1:0] {
    PhType,
    PhLen,
    PhValue
  } phase_e;

  typedef enum logic [2:0] {
    KindNone,
    KindPort,
    KindHb,
    KindV4,
    KindV6,
    KindPeer
  } kind_e;

  localparam int SeenPort = 0;
  localparam int SeenHb   = 1;
  localparam int SeenAddr = 2;
  localparam int SeenPeer = 3;

  logic [pov_pkg::LenW-1:0]   byte_cnt_q, byte_cnt_d;
  logic [pov_pkg::LenW-1:0]   decl_len_q, decl_len_d;
  phase_e                     phase_q, phase_d;
  kind_e                      kind_q, kind_d;
  logic [pov_pkg::OctetW-1:0] tlv_len_q, tlv_len_d;
  logic [pov_pkg::OctetW-1:0] offset_q, offset_d;
  logic [3:0]                 seen_q, seen_d;
  pov_pkg::err_e              first_err_q, first_err_d;

  pov_pkg::result_t           res_q [2];
  logic                       res_wr_q, res_rd_q;
  logic [1:0]                 res_cnt_q;

  logic                       consume, res_push, res_pop;
  logic                       hit;
  pov_pkg::err_e              hit_code;
  pov_pkg::err_e              verdict;
  logic                       last_value;
  logic                       prefix_full;
  pov_pkg::cls_beat_t         bt;

  assign bt       = q_beat_i;
  assign consume  = !q_empty_i && (res_cnt_q != 2'd2);
  assign q_rd_o   = consume;
  assign res_push = consume && bt.final_octet;
  assign empty    = (res_cnt_q == 2'd0);
  assign res_pop  = pop && !empty;
  assign result_o = res_q[res_rd_q];

  assign last_value  = ({1'b0, offset_q} + 9'd1) == {1'b0, tlv_len_q};
  assign prefix_full = (kind_q == KindV4) ? bt.is_v4_full : bt.is_v6_full;

  // Next walker state for the beat at the head of the queue.
  always_comb begin
    decl_len_d = decl_len_q;
    phase_d    = phase_q;
    kind_d     = kind_q;
    tlv_len_d  = tlv_len_q;
    offset_d   = offset_q;
    seen_d     = seen_q;
    hit        = 1'b0;
    hit_code   = pov_pkg::ErrNone;

    if (byte_cnt_q == 16'd0) begin
      if (!bt.is_offer) begin
        hit      = 1'b1;
        hit_code = pov_pkg::ErrType;
      end
    end else if (byte_cnt_q == 16'd1) begin
      decl_len_d = {bt.octet, decl_len_q[pov_pkg::OctetW-1:0]};
    end else if (byte_cnt_q == 16'd2) begin
      decl_len_d = {decl_len_q[pov_pkg::LenW-1:pov_pkg::OctetW], bt.octet};
    end else begin
      unique case (phase_q)
        PhType: begin
          kind_d  = KindNone;
          phase_d = PhLen;
          // Equal codes resolve in the order port, heartbeat, IPv4, IPv6, peer.
          if (bt.m_port) begin
            if (seen_q[SeenPort]) begin
              hit = 1'b1; hit_code = pov_pkg::ErrDupPort;
            end else begin
              kind_d = KindPort;
            end
          end else if (bt.m_hb) begin
            if (seen_q[SeenHb]) begin
              hit = 1'b1; hit_code = pov_pkg::ErrDupHb;
            end else begin
              kind_d = KindHb;
            end
          end else if (bt.m_v4) begin
            kind_d = KindV4;
          end else if (bt.m_v6) begin
            kind_d = KindV6;
          end else if (bt.m_peer) begin
            if (seen_q[SeenPeer]) begin
              hit = 1'b1; hit_code = pov_pkg::ErrDupPeer;
            end else begin
              kind_d = KindPeer;
            end
          end else begin
            hit = 1'b1; hit_code = pov_pkg::ErrUnknownTlv;
          end
        end
        PhLen: begin
          tlv_len_d = bt.octet;
          offset_d  = '0;
          phase_d   = bt.is_zero ? PhType : PhValue;
          unique case (kind_q)
            KindPort: begin
              if (!bt.is_short_len) begin
                hit = 1'b1; hit_code = pov_pkg::ErrPortLen;
              end else begin
                seen_d[SeenPort] = 1'b1;
              end
              kind_d = KindNone;
            end
            KindHb: begin
              if (!bt.is_short_len) begin
                hit = 1'b1; hit_code = pov_pkg::ErrHbLen;
              end else begin
                seen_d[SeenHb] = 1'b1;
              end
              kind_d = KindNone;
            end
            KindV4: begin
              if (!bt.is_v4_len) begin
                hit = 1'b1; hit_code = pov_pkg::ErrAddrLen; kind_d = KindNone;
              end
            end
            KindV6: begin
              if (!bt.is_v6_len) begin
                hit = 1'b1; hit_code = pov_pkg::ErrAddrLen; kind_d = KindNone;
              end
            end
            KindPeer: begin
              // An empty peer type string is legal.
              if (bt.is_zero) begin
                seen_d[SeenPeer] = 1'b1;
                kind_d = KindNone;
              end
            end
            default: kind_d = kind_q;
          endcase
        end
        PhValue: begin
          if (kind_q == KindV4 || kind_q == KindV6) begin
            if (offset_q == '0 && !bt.is_add) begin
              hit = 1'b1; hit_code = pov_pkg::ErrAddFlag; kind_d = KindNone;
            end else if (last_value) begin
              if (!prefix_full) begin
                hit = 1'b1; hit_code = pov_pkg::ErrPrefix;
              end else begin
                seen_d[SeenAddr] = 1'b1;
              end
              kind_d = KindNone;
            end
          end else if (kind_q == KindPeer) begin
            if (bt.is_zero) begin
              hit = 1'b1; hit_code = pov_pkg::ErrPeerNul; kind_d = KindNone;
            end else if (last_value) begin
              seen_d[SeenPeer] = 1'b1;
              kind_d = KindNone;
            end
          end
          if (last_value) begin
            phase_d  = PhType;
            offset_d = '0;
          end else begin
            offset_d = offset_q + 1'b1;
          end
        end
        default: phase_d = PhType;
      endcase
    end

    first_err_d = (hit && first_err_q == pov_pkg::ErrNone) ? hit_code : first_err_q;
    // The count sticks at its top value on very long packets.
    byte_cnt_d  = (byte_cnt_q == '1) ? byte_cnt_q : byte_cnt_q + 1'b1;
  end

  // Verdict for a packet that ends on this beat, in reporting precedence.
  always_comb begin
    if (byte_cnt_d < pov_pkg::MinPacket) begin
      verdict = pov_pkg::ErrShort;
    end else if (first_err_d == pov_pkg::ErrType) begin
      verdict = pov_pkg::ErrType;
    end else if (decl_len_d != byte_cnt_d) begin
      verdict = pov_pkg::ErrLength;
    end else if (first_err_d != pov_pkg::ErrNone) begin
      verdict = first_err_d;
    end else if (!seen_d[SeenAddr]) begin
      verdict = pov_pkg::ErrNoAddr;
    end else if (!seen_d[SeenPort]) begin
      verdict = pov_pkg::ErrNoPort;
    end else if (!seen_d[SeenHb]) begin
      verdict = pov_pkg::ErrNoHb;
    end else if (phase_d != PhType) begin
      verdict = pov_pkg::ErrOverrun;
    end else begin
      verdict = pov_pkg::ErrNone;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q].accepted   <= (verdict == pov_pkg::ErrNone);
      res_q[res_wr_q].error_code <= verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q  <= '0;
      decl_len_q  <= '0;
      phase_q     <= PhType;
      kind_q      <= KindNone;
      tlv_len_q   <= '0;
      offset_q    <= '0;
      seen_q      <= '0;
      first_err_q <= pov_pkg::ErrNone;
      res_wr_q    <= 1'b0;
      res_rd_q    <= 1'b0;
      res_cnt_q   <= 2'd0;
    end else begin
      if (consume) begin
        if (bt.final_octet) begin
          byte_cnt_q  <= '0;
          decl_len_q  <= '0;
          phase_q     <= PhType;
          kind_q      <= KindNone;
          tlv_len_q   <= '0;
          offset_q    <= '0;
          seen_q      <= '0;
          first_err_q <= pov_pkg::ErrNone;
        end else begin
          byte_cnt_q  <= byte_cnt_d;
          decl_len_q  <= decl_len_d;
          phase_q     <= phase_d;
          kind_q      <= kind_d;
          tlv_len_q   <= tlv_len_d;
          offset_q    <= offset_d;
          seen_q      <= seen_d;
          first_err_q <= first_err_d;
        end
      end
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 1'b1;
      end
    end
  end

  `POV_ASSERT_NEXT(a_pkt_clear, consume && bt.final_octet, byte_cnt_q == '0 && first_err_q == pov_pkg::ErrNone, "walker state not cleared after last byte")
  `POV_ASSERT_IMPL(a_value_len, phase_q == PhValue, tlv_len_q != '0, "value phase entered for an empty TLV")

endmodule

/* test/peer_offer_tlv_validator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Peer offer TLV validator testbench
// Streams peer offer signals into the validator, one byte beat at a time, and
// checks every verdict against a cycle-free model of the TLV walk. Both sides
// idle at random, and the type codes are moved through several settings.
// ----------------------------------------------------------------------------
module peer_offer_tlv_validator_tb;

  localparam int PhaseBytes   = 330;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 12;
  localparam int IdleLimit    = 4000;

  localparam int SeenPort = 0;
  localparam int SeenHb   = 1;
  localparam int SeenAddr = 2;
  localparam int SeenPeer = 3;

  typedef enum logic [1:0] {PhType, PhLen, PhValue} walk_phase_e;
  typedef enum logic [2:0] {KindNone, KindPort, KindHb, KindV4, KindV6, KindPeer} tlv_kind_e;
  typedef enum int {TokPort, TokHb, TokAddr, TokPeer, TokUnknown, TokSpareV4} tok_e;

  // Kinds of damage that the packet builder can apply to an otherwise good offer.
  typedef enum int {
    FaultNone, FaultType, FaultLen, FaultShort, FaultDupPort, FaultPortLen,
    FaultDupHb, FaultHbLen, FaultAddrLen, FaultAddFlag, FaultPrefix, FaultDupPeer,
    FaultPeerNul, FaultUnknown, FaultNoAddr, FaultNoPort, FaultNoHb, FaultOverrun,
    FaultNoise
  } fault_e;

  logic                         clk_i     = 1'b0;
  logic                         rst_ni    = 1'b0;
  logic                         push      = 1'b0;
  logic                         full;
  pov_pkg::in_beat_t            in_beat_i = '0;
  logic                         empty;
  logic                         pop       = 1'b0;
  pov_pkg::result_t             result_o;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [pov_pkg::CfgAddrW-1:0] paddr     = '0;
  logic [pov_pkg::CfgDataW-1:0] pwdata    = '0;
  logic [pov_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  peer_offer_tlv_validator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Byte beats waiting to be offered, and verdicts waiting to come out.
  pov_pkg::in_beat_t beats_pending[$];
  pov_pkg::result_t  verdicts_due[$];
  logic [7:0]        frame[$];

  // Model copy of the type codes and of the per-packet walk state.
  pov_pkg::cfg_t   codes       = pov_pkg::CfgReset;
  logic [15:0]     pk_count    = '0;
  logic [15:0]     pk_declared = '0;
  walk_phase_e     pk_phase    = PhType;
  tlv_kind_e       pk_kind     = KindNone;
  logic [7:0]      pk_tlv_len  = '0;
  logic [7:0]      pk_offset   = '0;
  logic [3:0]      pk_seen     = '0;
  pov_pkg::err_e   pk_first    = pov_pkg::ErrNone;

  int          mismatch_count = 0;
  int          packets_sent   = 0;
  int          bytes_sent     = 0;
  int          verdicts_seen  = 0;
  int          verdicts_ok    = 0;
  logic [17:0] codes_hit      = '0;
  int          idle_cycles    = 0;
  int          holds_asked    = 0;

  function automatic void note_fault(input pov_pkg::err_e e);
    if (pk_first == pov_pkg::ErrNone) pk_first = e;
  endfunction

  // Advances the model walk by one byte and queues the verdict on the last byte.
  task automatic predict_verdict(input pov_pkg::in_beat_t b);
    logic [7:0]       o;
    logic             value_done;
    pov_pkg::err_e    code;
    pov_pkg::result_t r;
    o = b.octet;
    if (pk_count == 16'd0) begin
      if (o != codes.offer_code) note_fault(pov_pkg::ErrType);
    end else if (pk_count == 16'd1) begin
      pk_declared = {o, 8'h00};
    end else if (pk_count == 16'd2) begin
      pk_declared[7:0] = o;
    end else begin
      case (pk_phase)
        PhType: begin
          // Equal codes resolve in the fixed order port, heartbeat, v4, v6, peer.
          pk_kind = KindNone;
          if (o == codes.port_code) begin
            if (pk_seen[SeenPort]) note_fault(pov_pkg::ErrDupPort);
            else pk_kind = KindPort;
          end else if (o == codes.hb_code) begin
            if (pk_seen[SeenHb]) note_fault(pov_pkg::ErrDupHb);
            else pk_kind = KindHb;
          end else if (o == codes.v4_code) begin
            pk_kind = KindV4;
          end else if (o == codes.v6_code) begin
            pk_kind = KindV6;
          end else if (o == codes.peer_code) begin
            if (pk_seen[SeenPeer]) note_fault(pov_pkg::ErrDupPeer);
            else pk_kind = KindPeer;
          end else begin
            note_fault(pov_pkg::ErrUnknownTlv);
          end
          pk_phase = PhLen;
        end
        PhLen: begin
          pk_tlv_len = o;
          pk_offset  = '0;
          case (pk_kind)
            KindPort: begin
              if (o != pov_pkg::ShortTlvLen) note_fault(pov_pkg::ErrPortLen);
              else pk_seen[SeenPort] = 1'b1;
              pk_kind = KindNone;
            end
            KindHb: begin
              if (o != pov_pkg::ShortTlvLen) note_fault(pov_pkg::ErrHbLen);
              else pk_seen[SeenHb] = 1'b1;
              pk_kind = KindNone;
            end
            KindV4: begin
              if (o != pov_pkg::V4TlvLen) begin
                note_fault(pov_pkg::ErrAddrLen);
                pk_kind = KindNone;
              end
            end
            KindV6: begin
              if (o != pov_pkg::V6TlvLen) begin
                note_fault(pov_pkg::ErrAddrLen);
                pk_kind = KindNone;
              end
            end
            KindPeer: begin
              // An empty peer type string is valid and complete at once.
              if (o == 8'd0) begin
                pk_seen[SeenPeer] = 1'b1;
                pk_kind = KindNone;
              end
            end
            default: ;
          endcase
          pk_phase = (o == 8'd0) ? PhType : PhValue;
        end
        default: begin
          value_done = ({1'b0, pk_offset} + 9'd1) == {1'b0, pk_tlv_len};
          if (pk_kind == KindV4 || pk_kind == KindV6) begin
            if (pk_offset == 8'd0 && o != pov_pkg::AddFlag) begin
              note_fault(pov_pkg::ErrAddFlag);
              pk_kind = KindNone;
            end else if (value_done) begin
              if (o != ((pk_kind == KindV4) ? pov_pkg::V4FullPrefix
                                            : pov_pkg::V6FullPrefix)) begin
                note_fault(pov_pkg::ErrPrefix);
              end else begin
                pk_seen[SeenAddr] = 1'b1;
              end
              pk_kind = KindNone;
            end
          end else if (pk_kind == KindPeer) begin
            if (o == 8'd0) begin
              note_fault(pov_pkg::ErrPeerNul);
              pk_kind = KindNone;
            end else if (value_done) begin
              pk_seen[SeenPeer] = 1'b1;
              pk_kind = KindNone;
            end
          end
          if (value_done) begin
            pk_phase  = PhType;
            pk_offset = '0;
          end else begin
            pk_offset = pk_offset + 8'd1;
          end
        end
      endcase
    end
    // The byte counter sticks at its top value on over-long packets.
    if (pk_count != 16'hFFFF) pk_count = pk_count + 16'd1;

    if (b.final_octet) begin
      if (pk_count < pov_pkg::MinPacket) code = pov_pkg::ErrShort;
      else if (pk_first == pov_pkg::ErrType) code = pov_pkg::ErrType;
      else if (pk_declared != pk_count) code = pov_pkg::ErrLength;
      else if (pk_first != pov_pkg::ErrNone) code = pk_first;
      else if (!pk_seen[SeenAddr]) code = pov_pkg::ErrNoAddr;
      else if (!pk_seen[SeenPort]) code = pov_pkg::ErrNoPort;
      else if (!pk_seen[SeenHb]) code = pov_pkg::ErrNoHb;
      else if (pk_phase != PhType) code = pov_pkg::ErrOverrun;
      else code = pov_pkg::ErrNone;
      r.accepted   = (code == pov_pkg::ErrNone);
      r.error_code = code;
      verdicts_due.push_back(r);
      pk_count    = '0;
      pk_declared = '0;
      pk_phase    = PhType;
      pk_kind     = KindNone;
      pk_tlv_len  = '0;
      pk_offset   = '0;
      pk_seen     = '0;
      pk_first    = pov_pkg::ErrNone;
    end
  endtask

  // One register write: setup beat, then access beat until pready.
  task automatic write_reg(input pov_pkg::cfg_reg_e idx, input logic [7:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      pov_pkg::RegOffer: codes.offer_code = val;
      pov_pkg::RegPort:  codes.port_code  = val;
      pov_pkg::RegHb:    codes.hb_code    = val;
      pov_pkg::RegV4:    codes.v4_code    = val;
      pov_pkg::RegV6:    codes.v6_code    = val;
      pov_pkg::RegPeer:  codes.peer_code  = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_codes(input pov_pkg::cfg_t c);
    write_reg(pov_pkg::RegOffer, c.offer_code);
    write_reg(pov_pkg::RegPort, c.port_code);
    write_reg(pov_pkg::RegHb, c.hb_code);
    write_reg(pov_pkg::RegV4, c.v4_code);
    write_reg(pov_pkg::RegV6, c.v6_code);
    write_reg(pov_pkg::RegPeer, c.peer_code);
  endtask

  // Waits until the block has drained, then gives the walker time to go quiet.
  task automatic settle();
    while (beats_pending.size() != 0 || verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic ship_frame();
    pov_pkg::in_beat_t b;
    foreach (frame[k]) begin
      b.octet       = frame[k];
      b.final_octet = (k == frame.size() - 1);
      beats_pending.push_back(b);
    end
    packets_sent++;
    bytes_sent += frame.size();
  endtask

  function automatic fault_e pick_fault();
    if ($urandom_range(0, 9) < 4) return FaultNone;
    return fault_e'($urandom_range(1, int'(FaultNoise)));
  endfunction

  // Builds a peer offer in frame: the mandatory TLVs in random order with random
  // content, then at most one fault applied to the first place it fits.
  task automatic build_offer(input fault_e fault);
    tok_e       toks[$];
    tok_e       t;
    int         i, j, len, delta;
    logic [7:0] v, full_prefix;
    bit         armed, v6;
    frame.delete();
    if (fault == FaultShort) begin
      frame.push_back($urandom_range(0, 1) ? codes.offer_code : 8'($urandom));
      if ($urandom_range(0, 1)) frame.push_back(8'($urandom));
      return;
    end
    if (fault == FaultNoise) begin
      len = $urandom_range(1, 40);
      repeat (len) frame.push_back(8'($urandom));
      if (len > 3 && $urandom_range(0, 1)) begin
        frame[0] = codes.offer_code;
        frame[1] = 8'(len >> 8);
        frame[2] = 8'(len);
      end
      return;
    end

    frame.push_back(codes.offer_code);
    frame.push_back(8'h00);
    frame.push_back(8'h00);
    if (fault != FaultNoPort) toks.push_back(TokPort);
    if (fault != FaultNoHb) toks.push_back(TokHb);
    if (fault != FaultNoAddr) toks.push_back(TokAddr);
    if ($urandom_range(0, 1) || fault == FaultDupPeer || fault == FaultPeerNul)
      toks.push_back(TokPeer);
    // Address TLVs may repeat without fault.
    if ($urandom_range(0, 3) == 0) toks.push_back(TokAddr);
    case (fault)
      FaultDupPort: toks.push_back(TokPort);
      FaultDupHb:   toks.push_back(TokHb);
      FaultDupPeer: toks.push_back(TokPeer);
      FaultUnknown: toks.push_back(TokUnknown);
      default: ;
    endcase
    for (i = toks.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = toks[i];
      toks[i] = toks[j];
      toks[j] = t;
    end
    // A trailing IPv4 TLV gives the overrun cut something to bite into.
    if (fault == FaultOverrun) toks.push_back(TokSpareV4);

    armed = 1'b1;
    foreach (toks[k]) begin
      case (toks[k])
        TokPort, TokHb: begin
          frame.push_back(toks[k] == TokPort ? codes.port_code : codes.hb_code);
          len = int'(pov_pkg::ShortTlvLen);
          if (armed && ((fault == FaultPortLen && toks[k] == TokPort) ||
                        (fault == FaultHbLen && toks[k] == TokHb))) begin
            do len = $urandom_range(0, 6); while (len == pov_pkg::ShortTlvLen);
            armed = 1'b0;
          end
          frame.push_back(8'(len));
          repeat (len) frame.push_back(8'($urandom));
        end
        TokAddr, TokSpareV4: begin
          v6 = (toks[k] == TokAddr) && $urandom_range(0, 1);
          full_prefix = v6 ? pov_pkg::V6FullPrefix : pov_pkg::V4FullPrefix;
          frame.push_back(v6 ? codes.v6_code : codes.v4_code);
          len = int'(v6 ? pov_pkg::V6TlvLen : pov_pkg::V4TlvLen);
          if (armed && fault == FaultAddrLen && toks[k] == TokAddr) begin
            do len = $urandom_range(0, 24);
            while (len == (v6 ? pov_pkg::V6TlvLen : pov_pkg::V4TlvLen));
            armed = 1'b0;
          end
          frame.push_back(8'(len));
          for (i = 0; i < len; i++) begin
            if (i == 0) begin
              v = pov_pkg::AddFlag;
              if (armed && fault == FaultAddFlag && toks[k] == TokAddr) begin
                do v = 8'($urandom); while (v == pov_pkg::AddFlag);
                armed = 1'b0;
              end
            end else if (i == len - 1) begin
              v = full_prefix;
              if (armed && fault == FaultPrefix && toks[k] == TokAddr) begin
                do v = 8'($urandom); while (v == full_prefix);
                armed = 1'b0;
              end
            end else begin
              v = 8'($urandom);
            end
            frame.push_back(v);
          end
        end
        TokPeer: begin
          frame.push_back(codes.peer_code);
          len = $urandom_range(0, 10);
          j = -1;
          if (armed && fault == FaultPeerNul) begin
            if (len == 0) len = 3;
            j = $urandom_range(0, len - 1);
            armed = 1'b0;
          end
          frame.push_back(8'(len));
          for (i = 0; i < len; i++) frame.push_back(i == j ? 8'h00 : 8'($urandom_range(1, 255)));
        end
        default: begin
          do v = 8'($urandom);
          while (v == codes.port_code || v == codes.hb_code || v == codes.v4_code ||
                 v == codes.v6_code || v == codes.peer_code);
          frame.push_back(v);
          len = $urandom_range(0, 5);
          frame.push_back(8'(len));
          repeat (len) frame.push_back(8'($urandom));
        end
      endcase
    end

    if (fault == FaultOverrun) begin
      repeat ($urandom_range(1, 7)) void'(frame.pop_back());
    end
    len = frame.size();
    if (fault == FaultLen) begin
      delta = $urandom_range(1, 3);
      if ($urandom_range(0, 1)) len += delta;
      else len -= delta;
    end
    frame[1] = 8'(len >> 8);
    frame[2] = 8'(len);
    if (fault == FaultType) frame[0] = codes.offer_code ^ 8'($urandom_range(1, 255));
  endtask

  // Sender: bursts of beats with random gaps, fed from beats_pending.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (beats_pending.size() == 0) begin
      push <= 1'b0;
    end else begin
      push      <= 1'b1;
      in_beat_i <= beats_pending[0];
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Receiver: switches between always ready, a rotating stall pattern and coin
  // flips, and serves any long hold-off that the stimulus asks for.
  int         holds_done   = 0;
  int         hold_left    = 0;
  int         pop_mode     = 0;
  int         mode_left    = 0;
  logic [7:0] stall_pattern = 8'b1011_0110;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HoldCycles;
      pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode  = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
      case (pop_mode)
        0:       pop <= 1'b1;
        1:       pop <= stall_pattern[0];
        default: pop <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Monitor: takes accepted beats into the model and checks each verdict beat.
  always @(posedge clk_i) begin : monitor
    pov_pkg::result_t want;
    bit               moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (!empty && pop) begin
        moved = 1'b1;
        verdicts_seen++;
        if (result_o.accepted) verdicts_ok++;
        if (result_o.error_code <= 5'd17) codes_hit[result_o.error_code] = 1'b1;
        if (verdicts_due.size() == 0) begin
          $error("verdict with none expected: accepted %0d, error_code %0d",
                 result_o.accepted, result_o.error_code);
          mismatch_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (result_o.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, result_o.accepted);
            mismatch_count++;
          end
          if (result_o.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, result_o.error_code);
            mismatch_count++;
          end
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        void'(beats_pending.pop_front());
        predict_verdict(in_beat_i);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $error("no beat moved for %0d cycles", IdleLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    pov_pkg::cfg_t plan[4];
    logic [63:0]   rnd;
    int            p, phase_bytes;

    plan[0] = '{offer_code: 8'hFF, port_code: 8'h00, hb_code: 8'hFF,
                v4_code: 8'h80, v6_code: 8'hFE, peer_code: 8'h7F};
    // Shared codes: port wins over heartbeat and peer, v4 wins over v6.
    plan[1] = '{offer_code: 8'h5A, port_code: 8'h00, hb_code: 8'h00,
                v4_code: 8'h80, v6_code: 8'h80, peer_code: 8'h00};
    rnd = {$urandom, $urandom};
    plan[2] = rnd[47:0];
    plan[3] = pov_pkg::CfgReset;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (p = 0; p <= 4; p++) begin
      if (p == 0) begin
        // Packets of one and two bytes, a bare header, then the smallest offer
        // that passes every check.
        frame = '{8'hFF};
        ship_frame();
        frame = '{codes.offer_code, 8'h00};
        ship_frame();
        frame = '{codes.offer_code, 8'h00, 8'h03};
        ship_frame();
        frame = '{codes.offer_code, 8'h00, 8'd19,
                  codes.port_code, pov_pkg::ShortTlvLen, 8'hFF, 8'h00,
                  codes.hb_code, pov_pkg::ShortTlvLen, 8'h00, 8'h05,
                  codes.v4_code, pov_pkg::V4TlvLen, pov_pkg::AddFlag,
                  8'd192, 8'd168, 8'd0, 8'd1, pov_pkg::V4FullPrefix};
        ship_frame();
      end else begin
        settle();
        set_codes(plan[p-1]);
      end
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        build_offer(pick_fault());
        phase_bytes += frame.size();
        ship_frame();
      end
      // The receiver stalls for a long stretch while this phase is in flight,
      // so the byte queue fills and full must hold the sender off.
      if (p == 1) holds_asked++;
    end
    settle();

    $display("Covered %0d packets (%0d bytes) under 5 type code settings.",
             packets_sent, bytes_sent);
    $display("Checked %0d verdicts, %0d accepted, %0d distinct verdict codes seen.",
             verdicts_seen, verdicts_ok, $countones(codes_hit));
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* peer_offer_tlv_validator.f */
+incdir+hw/rtl
hw/rtl/pov_pkg.sv
hw/rtl/pov_cfg_regs.sv
hw/rtl/pov_front.sv
hw/rtl/pov_queue.sv
hw/rtl/pov_back.sv
hw/rtl/peer_offer_tlv_validator.sv
test/peer_offer_tlv_validator_tb.sv
